@@ hw/rtl/wosm_pkg.sv @@
// Shared types, constants and helpers of the window occlusion span mask block.
`timescale 1ns / 1ps
package wosm_pkg;

  // Pixel coordinate width: holds a clamped span end for lines of up to 4096 pixels.
  localparam int PIX_W = 13;
  localparam logic [6:0] WPL_RESET = 7'd40;
  localparam logic [4:0] NONE_FOUND = 5'd17;

  // One classified window as the front hands it to the back.
  typedef struct packed {
    logic             clr;
    logic             act;
    logic [15:0]      line_base;
    logic [9:0]       row;
    logic [9:0]       left;
    logic [PIX_W-1:0] stop;
  } desc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_SCAN,
    ST_FIN
  } st_e;

  // Index of the lowest set bit of a 17-bit vector, NONE_FOUND if it is zero.
  function automatic logic [4:0] first_set(input logic [16:0] v);
    logic [4:0] r;
    r = NONE_FOUND;
    for (int i = 16; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/wosm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wosm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/wosm_front.sv @@
// Front end: accepts windows, tests them against the line and queues descriptors.
`timescale 1ns / 1ps
module wosm_front #(
  parameter int LINE_PIXELS = 640
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            new_line_i,
  input  logic [9:0]      line_i,
  input  logic [9:0]      window_top_i,
  input  logic [9:0]      window_height_i,
  input  logic [9:0]      window_left_i,
  input  logic [9:0]      window_width_i,
  output logic            desc_valid_o,
  input  logic            desc_ready_i,
  output wosm_pkg::desc_t desc_o
);
  import wosm_pkg::*;

  logic [6:0]       wpl_q;
  logic [10:0]      bottom;
  logic [10:0]      span_end;
  logic [PIX_W-1:0] stop;
  logic             on_line;
  desc_t            new_desc;
  logic             push;
  logic             pop;
  desc_t            fifo_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  // Words-per-line register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpl_q <= WPL_RESET;
    end else if (cfg_we_i) begin
      wpl_q <= cfg_wdata_i;
    end
  end

  // Classify the window: on the line, and the span clipped to the line width.
  always_comb begin
    bottom   = 11'(window_top_i) + 11'(window_height_i);
    on_line  = (window_top_i <= line_i) && (11'(line_i) < bottom);
    span_end = 11'(window_left_i) + 11'(window_width_i);
    if (PIX_W'(span_end) > PIX_W'(LINE_PIXELS)) begin
      stop = PIX_W'(LINE_PIXELS);
    end else begin
      stop = PIX_W'(span_end);
    end
    new_desc.clr       = new_line_i;
    new_desc.act       = on_line && (stop > PIX_W'(window_left_i));
    new_desc.line_base = 16'(line_i) * 16'(wpl_q);
    new_desc.row       = line_i - window_top_i;
    new_desc.left      = window_left_i;
    new_desc.stop      = stop;
  end

  // Windows that neither clear nor cover anything are dropped here.
  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o && (new_desc.clr || new_desc.act);
  assign desc_valid_o = (cnt_q != 2'd0);
  assign pop          = desc_valid_o && desc_ready_i;
  assign desc_o       = fifo_q[rd_ptr_q];

  // Two-entry descriptor queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_desc;
    end
  end

endmodule

@@ hw/rtl/wosm_back.sv @@
// Back end: scans the coverage map word by word and emits one segment per uncovered run, up to MAX_SEGMENTS per window.
`timescale 1ns / 1ps
module wosm_back #(
  parameter int LINE_PIXELS  = 640,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  output logic            desc_ready_o,
  input  wosm_pkg::desc_t desc_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     word_address_o,
  output logic [9:0]      window_row_o,
  output logic [9:0]      column_offset_o,
  output logic [15:0]     begin_mask_o,
  output logic [5:0]      word_count_o,
  output logic [15:0]     end_mask_o,
  output logic            truncated_o,
  output logic            last_o
);
  import wosm_pkg::*;

  localparam int NW  = (LINE_PIXELS + 15) / 16;
  localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int NCW = $clog2(MAX_SEGMENTS + 1);

  st_e              state_q, state_d;
  desc_t            cur_q;
  logic [NW-1:0]    valid_q;
  logic [AW-1:0]    w_q;
  logic [AW-1:0]    w_last;
  logic [15:0]      rdata;
  logic [15:0]      cov;
  logic [15:0]      rng;
  logic [15:0]      u_q;
  logic [4:0]       p_q;
  logic             in_run_q;
  logic [PIX_W-1:0] run_start_q;
  logic [NCW-1:0]   n_q;
  logic             cut_q;
  logic             pend_v_q;
  logic [PIX_W-1:0] pend_start_q, pend_end_q;
  logic [PIX_W-1:0] base;
  logic             last_word;
  logic [16:0]      hi, ext_set, ext_clr;
  logic [4:0]       s_idx, e_idx;
  logic             found, wdone, stall, out_free, move, move_last;
  logic [PIX_W-1:0] f_start, f_end;
  logic             f_in_run;
  logic             ram_we;

  // Coverage RAM, one 16-pixel word per entry, valid bits give the cleared state.
  wosm_ram #(.WIDTH(16), .DEPTH(NW), .AW(AW)) u_cov (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_q),
    .wdata_i (cov | rng),
    .raddr_i (w_q),
    .rdata_o (rdata)
  );

  assign w_last    = AW'((cur_q.stop - PIX_W'(1)) >> 4);
  assign base      = PIX_W'({w_q, 4'b0000});
  assign last_word = (w_q == w_last);
  assign cov       = valid_q[w_q] ? rdata : 16'h0000;
  assign ram_we    = (state_q == ST_LD);
  assign out_free  = !out_valid_o || out_ready_i;

  // Window range mask over the current word.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rng[i] = ((base + PIX_W'(i)) >= PIX_W'(cur_q.left)) &&
               ((base + PIX_W'(i)) < cur_q.stop);
    end
  end

  // Run search within the loaded word; bit 16 closes a run at the span end.
  always_comb begin
    hi       = 17'(34'h1ffff << p_q);
    ext_set  = {1'b0, u_q};
    ext_clr  = {last_word, ~u_q};
    s_idx    = first_set(ext_set & hi);
    e_idx    = NONE_FOUND;
    found    = 1'b0;
    wdone    = 1'b0;
    f_in_run = in_run_q;
    f_start  = run_start_q;
    f_end    = base + PIX_W'(e_idx);
    if (!in_run_q) begin
      if (s_idx == NONE_FOUND) begin
        wdone = 1'b1;
      end else begin
        f_start = base + PIX_W'(s_idx);
        e_idx   = first_set(ext_clr & 17'(34'h1ffff << s_idx));
        if (e_idx == NONE_FOUND) begin
          f_in_run = 1'b1;
          wdone    = 1'b1;
        end else begin
          found = 1'b1;
        end
      end
    end else begin
      e_idx = first_set(ext_clr & hi);
      if (e_idx == NONE_FOUND) begin
        wdone = 1'b1;
      end else begin
        found    = 1'b1;
        f_in_run = 1'b0;
      end
    end
    f_end = base + PIX_W'(e_idx);
  end

  // A kept run, or the window's end, pushes the pending run out, so it waits for a free output.
  always_comb begin
    stall     = 1'b0;
    move      = 1'b0;
    move_last = 1'b0;
    if (state_q == ST_SCAN && found && (n_q < NCW'(MAX_SEGMENTS))) begin
      stall = pend_v_q && !out_free;
      move  = pend_v_q && out_free;
    end
    if (state_q == ST_FIN && pend_v_q) begin
      stall     = !out_free;
      move      = out_free;
      move_last = out_free;
    end
  end

  assign desc_ready_o = (state_q == ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (desc_valid_i && desc_i.act) state_d = ST_RD;
      end
      ST_RD:   state_d = ST_LD;
      ST_LD:   state_d = ST_SCAN;
      ST_SCAN: begin
        if (wdone) state_d = last_word ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        if (!stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan control and coverage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      in_run_q <= 1'b0;
      pend_v_q <= 1'b0;
      n_q      <= '0;
      cut_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (desc_valid_i) begin
            if (desc_i.clr) valid_q <= '0;
            in_run_q <= 1'b0;
            pend_v_q <= 1'b0;
            n_q      <= '0;
            cut_q    <= 1'b0;
          end
        end
        ST_LD: begin
          valid_q[w_q] <= 1'b1;
        end
        ST_SCAN: begin
          if (!stall) begin
            in_run_q <= f_in_run;
            if (found) begin
              if (n_q < NCW'(MAX_SEGMENTS)) begin
                pend_v_q <= 1'b1;
                n_q      <= n_q + NCW'(1);
              end else begin
                cut_q <= 1'b1;
              end
            end
          end
        end
        ST_FIN: begin
          if (move) pend_v_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Scan datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && desc_valid_i) begin
      cur_q <= desc_i;
      w_q   <= AW'(desc_i.left >> 4);
    end
    if (state_q == ST_LD) begin
      u_q <= ~cov & rng;
      p_q <= 5'd0;
    end
    if (state_q == ST_SCAN && !stall) begin
      run_start_q <= f_start;
      if (found) p_q <= e_idx;
      if (wdone && !last_word) w_q <= w_q + AW'(1);
      if (found && (n_q < NCW'(MAX_SEGMENTS))) begin
        pend_start_q <= f_start;
        pend_end_q   <= f_end;
      end
    end
  end

  // Segment word split of the pending run, MSB first.
  logic [PIX_W-1:0] len;
  logic [4:0]       phase, extra, first;
  logic [PIX_W-1:0] full;
  logic [15:0]      bmask, emask;
  logic [5:0]       wcount;

  always_comb begin
    len    = pend_end_q - pend_start_q;
    phase  = {1'b0, pend_start_q[3:0]};
    extra  = {1'b0, len[3:0]};
    full   = len >> 4;
    first  = 5'd0;
    bmask  = 16'h0000;
    wcount = 6'(full);
    emask  = 16'h0000;
    if (phase != 5'd0) begin
      bmask = 16'(32'hffff >> phase);
      first = 5'd16 - phase;
    end
    if (phase != 5'd0 && full == '0 && first > extra) begin
      bmask  = bmask & 16'(32'hffff << (first - extra));
      wcount = 6'd0;
    end else begin
      if (first > extra) begin
        full  = full - PIX_W'(1);
        extra = extra + 5'd16;
      end
      wcount = 6'(full);
      emask  = ~16'(32'hffff >> (extra - first));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (move) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      word_address_o  <= cur_q.line_base + 16'(pend_start_q >> 4);
      window_row_o    <= cur_q.row;
      column_offset_o <= 10'(pend_start_q - PIX_W'(cur_q.left));
      begin_mask_o    <= bmask;
      word_count_o    <= wcount;
      end_mask_o      <= emask;
      truncated_o     <= move_last && cut_q;
      last_o          <= move_last;
    end
  end

endmodule

@@ hw/rtl/window_occlusion_span_masks.sv @@
// Top level of the window occlusion span mask block.
// The back takes each 16-pixel word a window spans through its read, load and scan states.
// Throughput: sequential; the back scans one window at a time through the coverage RAM port.
// A two-entry queue lets the front accept windows while the back scans.
// Reset: asynchronous, active low; coverage reads as uncovered and words_per_line is 40.
`timescale 1ns / 1ps
module window_occlusion_span_masks #(
  parameter int LINE_PIXELS  = 640,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        new_line_i,
  input  logic [9:0]  line_i,
  input  logic [9:0]  window_top_i,
  input  logic [9:0]  window_height_i,
  input  logic [9:0]  window_left_i,
  input  logic [9:0]  window_width_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] word_address_o,
  output logic [9:0]  window_row_o,
  output logic [9:0]  column_offset_o,
  output logic [15:0] begin_mask_o,
  output logic [5:0]  word_count_o,
  output logic [15:0] end_mask_o,
  output logic        truncated_o,
  output logic        last_o
);
  import wosm_pkg::*;

  desc_t desc;
  logic  desc_valid, desc_ready;

  // Front: classification and queue.
  wosm_front #(.LINE_PIXELS(LINE_PIXELS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .new_line_i, .line_i, .window_top_i, .window_height_i, .window_left_i,
    .window_width_i,
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready),
    .desc_o       (desc)
  );

  // Back: coverage scan and segment output.
  wosm_back #(.LINE_PIXELS(LINE_PIXELS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
    .clk_i, .rst_ni,
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .desc_i       (desc),
    .out_valid_o, .out_ready_i, .word_address_o, .window_row_o, .column_offset_o,
    .begin_mask_o, .word_count_o, .end_mask_o, .truncated_o, .last_o
  );

endmodule

@@ hw/rtl/wosm_checker.sv @@
// Port-level assertions of the window occlusion span mask block and their bind.
`timescale 1ns / 1ps
module wosm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] word_address_o,
  input logic [15:0] begin_mask_o,
  input logic [5:0]  word_count_o,
  input logic [15:0] end_mask_o,
  input logic        truncated_o,
  input logic        last_o
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_address_o))
    else $error("result dropped while stalled");

  // The truncation flag only rides on the final segment of a window.
  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> last_o)
    else $error("truncated set on a segment that is not last");

  // Every segment covers at least one pixel.
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && begin_mask_o == 16'h0000 && word_count_o == 6'd0 |->
      end_mask_o != 16'h0000)
    else $error("empty segment");

endmodule

bind window_occlusion_span_masks wosm_checker u_wosm_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .word_address_o, .begin_mask_o,
  .word_count_o, .end_mask_o, .truncated_o, .last_o
);

@@ dv/tb_window_occlusion_span_masks.sv @@
// Self-checking testbench of the window occlusion span mask block.
`timescale 1ns / 1ps
module tb_window_occlusion_span_masks;
  import wosm_pkg::*;

  localparam int LINE_PIX   = 640;
  localparam int MAX_SEG    = 16;
  localparam int SETTLE_CYC = 300;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    bit       new_line;
    bit [9:0] line;
    bit [9:0] top;
    bit [9:0] height;
    bit [9:0] left;
    bit [9:0] width;
  } window_t;

  typedef struct {
    bit [15:0] word_address;
    bit [9:0]  window_row;
    bit [9:0]  column_offset;
    bit [15:0] begin_mask;
    bit [5:0]  word_count;
    bit [15:0] end_mask;
    bit        truncated;
    bit        last;
  } span_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        new_line_i = 1'b0;
  logic [9:0]  line_i = '0;
  logic [9:0]  window_top_i = '0;
  logic [9:0]  window_height_i = '0;
  logic [9:0]  window_left_i = '0;
  logic [9:0]  window_width_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] word_address_o;
  logic [9:0]  window_row_o;
  logic [9:0]  column_offset_o;
  logic [15:0] begin_mask_o;
  logic [5:0]  word_count_o;
  logic [15:0] end_mask_o;
  logic        truncated_o;
  logic        last_o;

  window_t window_q[$];
  span_t   span_q[$];
  window_t held_window;
  bit      cov_map[LINE_PIX];
  int      words_per_line_model = 40;
  int      error_count = 0;
  int      cycle_count = 0;
  bit      tx_pacing = 1'b1;
  bit      rx_pacing = 1'b1;
  int      tx_gap = 0;
  int      rx_stall = 0;

  window_occlusion_span_masks dut (.*);

  // Free-running clock.
  always #10 clk_i = ~clk_i;

  // Splits one run into word address, begin mask, full word count and end mask.
  function automatic span_t make_span(window_t w, int start, int len);
    span_t s;
    int unsigned phase, extra, full, first, bmask;
    phase = start & 'hf;
    extra = len & 'hf;
    full = len >> 4;
    first = 0;
    bmask = 0;
    s.word_address = 16'(w.line * words_per_line_model + start / 16);
    s.window_row = 10'(w.line - w.top);
    s.column_offset = 10'(start - w.left);
    s.truncated = 1'b0;
    s.last = 1'b0;
    if (phase != 0) begin
      bmask = 'hffff >> phase;
      first = 16 - phase;
      if (full == 0 && first > extra) begin
        s.begin_mask = 16'(bmask & ('hffff << (first - extra)));
        s.word_count = '0;
        s.end_mask = '0;
        return s;
      end
      if (first > extra) begin
        full -= 1;
        extra += 16;
      end
    end
    s.begin_mask = 16'(bmask);
    s.word_count = 6'(full);
    s.end_mask = 16'(~('hffff >> (extra - first)));
    return s;
  endfunction

  // Marks the uncovered runs of one window covered and queues the spans of up to MAX_SEG of them.
  function automatic void predict_spans(window_t w);
    int pos, stop, start, n;
    bit cut;
    n = 0;
    cut = 1'b0;
    if (w.new_line) begin
      foreach (cov_map[i]) cov_map[i] = 1'b0;
    end
    if (!(w.top <= w.line && int'(w.line) < int'(w.top) + int'(w.height))) return;
    pos = w.left;
    stop = int'(w.left) + int'(w.width);
    while (pos < stop) begin
      if (pos >= LINE_PIX || cov_map[pos]) begin
        pos++;
        continue;
      end
      start = pos;
      while (pos < stop && pos < LINE_PIX && !cov_map[pos]) begin
        cov_map[pos] = 1'b1;
        pos++;
      end
      if (n < MAX_SEG) begin
        span_q.push_back(make_span(w, start, pos - start));
        n++;
      end else begin
        cut = 1'b1;
      end
    end
    if (n > 0) begin
      span_q[$].truncated = cut;
      span_q[$].last = 1'b1;
    end
  endfunction

  task automatic report(string field, int got, int want);
    $display("MISMATCH %s: got %0h, expected %0h", field, got, want);
    error_count++;
  endtask

  task automatic add_window(bit nl, int ln, int tp, int ht, int lf, int wd);
    window_t w;
    w.new_line = nl;
    w.line = 10'(ln);
    w.top = 10'(tp);
    w.height = 10'(ht);
    w.left = 10'(lf);
    w.width = 10'(wd);
    window_q.push_back(w);
  endtask

  // A scanline of windows, most of them on the line.
  task automatic add_scanline(int count);
    int ln, row;
    ln = $urandom_range(0, 1023);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_window(i == 0, ln, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 639), $urandom_range(0, 640));
      end else begin
        row = $urandom_range(0, (ln > 1022) ? 1022 : ln);
        add_window(i == 0, ln, ln - row, $urandom_range(row + 1, 1023),
                   $urandom_range(0, 639), $urandom_range(1, 640));
      end
    end
  endtask

  // Narrow windows leave a comb of holes, so the wide one behind them is cut.
  task automatic add_comb();
    int ln;
    ln = $urandom_range(0, 1022);
    for (int k = 0; k < 20; k++) add_window(k == 0, ln, 0, 1023, 2 * k + 1, 1);
    add_window(1'b0, ln, 0, 1023, 0, 640);
  endtask

  task automatic write_wpl(int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(value);
    words_per_line_model = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the sender off until every expected span has come and the block is quiet.
  task automatic drain();
    while (window_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Input driver: presents windows from the queue, with random gaps while tx_pacing is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_spans(held_window);
        tx_gap <= tx_pacing ? $urandom_range(0, 6) : 0;
        if (!tx_pacing && window_q.size() != 0) begin
          held_window = window_q.pop_front();
          new_line_i <= held_window.new_line;
          line_i <= held_window.line;
          window_top_i <= held_window.top;
          window_height_i <= held_window.height;
          window_left_i <= held_window.left;
          window_width_i <= held_window.width;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (window_q.size() != 0) begin
          held_window = window_q.pop_front();
          new_line_i <= held_window.new_line;
          line_i <= held_window.line;
          window_top_i <= held_window.top;
          window_height_i <= held_window.height;
          window_left_i <= held_window.left;
          window_width_i <= held_window.width;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Output monitor: random back-pressure while rx_pacing is set, and field-by-field comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    span_t e;
    int s;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (span_q.size() == 0) begin
          $display("MISMATCH unexpected span at address %0h", word_address_o);
          error_count++;
        end else begin
          e = span_q.pop_front();
          if (word_address_o !== e.word_address)
            report("word_address", word_address_o, e.word_address);
          if (window_row_o !== e.window_row) report("window_row", window_row_o, e.window_row);
          if (column_offset_o !== e.column_offset)
            report("column_offset", column_offset_o, e.column_offset);
          if (begin_mask_o !== e.begin_mask) report("begin_mask", begin_mask_o, e.begin_mask);
          if (word_count_o !== e.word_count) report("word_count", word_count_o, e.word_count);
          if (end_mask_o !== e.end_mask) report("end_mask", end_mask_o, e.end_mask);
          if (truncated_o !== e.truncated) report("truncated", truncated_o, e.truncated);
          if (last_o !== e.last) report("last", last_o, e.last);
        end
        s = rx_pacing ? $urandom_range(0, 6) : 0;
        if (s != 0) begin
          out_ready_i <= 1'b0;
          rx_stall <= s - 1;
        end
      end else if (!out_ready_i) begin
        if (rx_stall == 0) out_ready_i <= 1'b1;
        else rx_stall <= rx_stall - 1;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus sequence: directed windows, then random scanlines under several settings.
  initial begin
    int wpl_set[6];
    wpl_set = '{40, 1, 64, 0, 127, 0};
    wpl_set[5] = $urandom_range(2, 63);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, off-line and empty windows, short runs, the line edge.
    add_window(1'b1, 0, 0, 1, 0, 640);
    add_window(1'b0, 0, 0, 1, 0, 640);
    add_window(1'b1, 1023, 0, 1023, 639, 640);
    add_window(1'b1, 1023, 1023, 1023, 0, 640);
    add_window(1'b1, 100, 50, 50, 0, 16);
    add_window(1'b0, 100, 50, 51, 3, 5);
    add_window(1'b0, 100, 0, 0, 20, 30);
    add_window(1'b0, 100, 0, 200, 20, 0);
    add_window(1'b0, 100, 101, 10, 20, 30);
    add_window(1'b0, 100, 0, 1023, 5, 9);
    add_window(1'b0, 100, 0, 1023, 14, 20);
    add_window(1'b0, 100, 0, 1023, 0, 640);
    add_window(1'b1, 512, 500, 13, 17, 14);
    add_window(1'b0, 512, 500, 13, 7, 40);
    add_window(1'b0, 512, 500, 13, 600, 640);
    add_window(1'b0, 512, 500, 13, 0, 640);
    add_comb();

    foreach (wpl_set[p]) begin
      drain();
      write_wpl(wpl_set[p]);
      tx_pacing = (p != 2);
      rx_pacing = (p != 3);
      for (int n = 0; n < 3; n++) add_scanline($urandom_range(2, 4));
      if (p == 4) add_comb();
    end

    drain();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/wosm_pkg.sv
hw/rtl/wosm_ram.sv
hw/rtl/wosm_front.sv
hw/rtl/wosm_back.sv
hw/rtl/window_occlusion_span_masks.sv
hw/rtl/wosm_checker.sv
dv/tb_window_occlusion_span_masks.sv
